// ===== sv/envkv_pkg.sv =====
// ----------------------------------------------------------------------------
// envkv_pkg
// Shared types and constants of the environment-file tokenizer: result kinds,
// character codes, configuration register indexes and the result plan that
// the parser hands to the emitter.
// ----------------------------------------------------------------------------
package envkv_pkg;

	localparam int SPACE_DEPTH_DEF = 16;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NL_A = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NL_B = 1'b1;

	localparam logic [7:0] NL_A_RESET = 8'd10;
	localparam logic [7:0] NL_B_RESET = 8'd13;

	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic [15:0] LINE_FIRST = 16'd1;
	localparam logic [15:0] LINE_SAT   = 16'hFFFF;

	typedef enum logic [2:0] {
		KIND_KEY      = 3'd0,
		KIND_VALUE    = 3'd1,
		KIND_PAIR_END = 3'd2,
		KIND_DISCARD  = 3'd3,
		KIND_OVERFLOW = 3'd4
	} kind_t;

	// Results of one item: held whitespace first, then the main result,
	// then the end-of-text result.
	typedef struct packed {
		kind_t       flush_kind;
		logic        main_v;
		kind_t       main_kind;
		logic [7:0]  main_byte;
		logic        tail_v;
		kind_t       tail_kind;
		logic [15:0] line;
	} plan_t;

endpackage

// ===== sv/envkv_if.sv =====
// ----------------------------------------------------------------------------
// envkv_if
// Valid/ready channels of the tokenizer: text bytes in, tokens out.
// ----------------------------------------------------------------------------
interface envkv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, text_byte, end_of_text, input ready);
	modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

interface envkv_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [7:0]  token_byte;
	logic [15:0] line_number;
	logic        run_last;

	modport source (output valid, token_kind, token_byte, line_number, run_last, input ready);
	modport sink (input valid, token_kind, token_byte, line_number, run_last, output ready);
endinterface

// ===== sv/envkv_parse.sv =====
// ----------------------------------------------------------------------------
// envkv_parse
// Parse state machine, line counter and trailing-whitespace buffer. Each
// accepted byte updates the state and yields a result plan.
// ----------------------------------------------------------------------------
module envkv_parse import envkv_pkg::*; #(
	parameter int SPACE_DEPTH = SPACE_DEPTH_DEF,
	parameter int CntW = $clog2(SPACE_DEPTH + 1),
	parameter int IdxW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]           wr_data,
	input  logic                 in_accept,
	input  logic [7:0]           text_byte,
	input  logic                 end_of_text,
	output plan_t                plan,
	output logic [CntW-1:0]      flush_n,
	input  logic                 rd_en,
	input  logic [IdxW-1:0]      rd_idx,
	output logic [7:0]           rd_data
);

	typedef enum logic [10:0] {
		M_PRE_KEY     = 11'b000_0000_0001,
		M_KEY         = 11'b000_0000_0010,
		M_PRE_VALUE   = 11'b000_0000_0100,
		M_VALUE       = 11'b000_0000_1000,
		M_VALUE_ESC   = 11'b000_0001_0000,
		M_SQ          = 11'b000_0010_0000,
		M_SQ_ESC      = 11'b000_0100_0000,
		M_DQ          = 11'b000_1000_0000,
		M_DQ_ESC      = 11'b001_0000_0000,
		M_COMMENT     = 11'b010_0000_0000,
		M_COMMENT_ESC = 11'b100_0000_0000
	} mode_t;

	mode_t           mode_q, mode_d, mode_sw;
	logic [15:0]     line_q, line_d, line_sw;
	logic [CntW-1:0] pcount_q, pcount_d;
	logic [7:0]      nl_a_q, nl_b_q;
	logic [7:0]      space_mem [SPACE_DEPTH];
	logic [7:0]      rd_data_q;

	logic       is_nl, is_ws, is_cmt;
	logic       line_inc, hold, hold_wr, do_flush;
	logic       main_v;
	kind_t      main_kind, flush_kind;
	logic       tail_v;
	kind_t      tail_kind;
	logic       value_mode;

	assign is_nl  = (text_byte == nl_a_q) || (text_byte == nl_b_q);
	assign is_ws  = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
	                (text_byte == CH_LF) || (text_byte == CH_CR);
	assign is_cmt = (text_byte == CH_HASH) || (text_byte == CH_SEMI);

	always_comb begin
		mode_sw    = mode_q;
		line_inc   = 1'b0;
		pcount_d   = pcount_q;
		hold       = 1'b0;
		do_flush   = 1'b0;
		flush_kind = KIND_KEY;
		main_v     = 1'b0;
		main_kind  = KIND_KEY;
		case (mode_q)
			M_KEY: begin
				if (is_nl) begin
					mode_sw   = M_PRE_KEY;
					pcount_d  = '0;
					line_inc  = 1'b1;
					main_v    = 1'b1;
					main_kind = KIND_DISCARD;
				end else if (text_byte == CH_EQUAL) begin
					mode_sw  = M_PRE_VALUE;
					pcount_d = '0;
				end else if (is_ws) begin
					hold = 1'b1;
				end else begin
					do_flush   = 1'b1;
					flush_kind = KIND_KEY;
					main_v     = 1'b1;
					main_kind  = KIND_KEY;
				end
			end
			M_PRE_VALUE: begin
				if (is_nl) begin
					mode_sw   = M_PRE_KEY;
					line_inc  = 1'b1;
					main_v    = 1'b1;
					main_kind = KIND_PAIR_END;
				end else if (text_byte == CH_SQUOTE) begin
					mode_sw = M_SQ;
				end else if (text_byte == CH_DQUOTE) begin
					mode_sw = M_DQ;
				end else if (text_byte == CH_BSLASH) begin
					mode_sw = M_VALUE_ESC;
				end else if (!is_ws) begin
					mode_sw   = M_VALUE;
					main_v    = 1'b1;
					main_kind = KIND_VALUE;
				end
			end
			M_VALUE: begin
				if (is_nl) begin
					mode_sw   = M_PRE_KEY;
					pcount_d  = '0;
					line_inc  = 1'b1;
					main_v    = 1'b1;
					main_kind = KIND_PAIR_END;
				end else if (text_byte == CH_BSLASH) begin
					do_flush   = 1'b1;
					flush_kind = KIND_VALUE;
					mode_sw    = M_VALUE_ESC;
				end else if (is_ws) begin
					hold = 1'b1;
				end else begin
					do_flush   = 1'b1;
					flush_kind = KIND_VALUE;
					main_v     = 1'b1;
					main_kind  = KIND_VALUE;
				end
			end
			M_VALUE_ESC, M_SQ_ESC, M_DQ_ESC: begin
				// drop an escaped line end
				mode_sw   = (mode_q == M_VALUE_ESC) ? M_VALUE :
				            (mode_q == M_SQ_ESC) ? M_SQ : M_DQ;
				main_v    = !is_nl;
				main_kind = KIND_VALUE;
			end
			M_SQ: begin
				if (text_byte == CH_SQUOTE) begin
					mode_sw = M_PRE_VALUE;
				end else if (text_byte == CH_BSLASH) begin
					mode_sw = M_SQ_ESC;
				end else begin
					main_v    = 1'b1;
					main_kind = KIND_VALUE;
				end
			end
			M_DQ: begin
				if (text_byte == CH_DQUOTE) begin
					mode_sw = M_PRE_VALUE;
				end else if (text_byte == CH_BSLASH) begin
					mode_sw = M_DQ_ESC;
				end else begin
					main_v    = 1'b1;
					main_kind = KIND_VALUE;
				end
			end
			M_COMMENT: begin
				if (text_byte == CH_BSLASH) begin
					mode_sw = M_COMMENT_ESC;
				end else if (is_nl) begin
					mode_sw  = M_PRE_KEY;
					line_inc = 1'b1;
				end
			end
			M_COMMENT_ESC: begin
				mode_sw = M_COMMENT;
			end
			default: begin
				if (is_cmt) begin
					mode_sw = M_COMMENT;
				end else if (!is_ws) begin
					mode_sw   = M_KEY;
					pcount_d  = '0;
					main_v    = 1'b1;
					main_kind = KIND_KEY;
				end else begin
					mode_sw = M_PRE_KEY;
				end
			end
		endcase

		// hold whitespace while there is room, flag it otherwise
		hold_wr = 1'b0;
		if (hold) begin
			if (pcount_q < CntW'(SPACE_DEPTH)) begin
				hold_wr  = 1'b1;
				pcount_d = pcount_q + CntW'(1);
			end else begin
				main_v    = 1'b1;
				main_kind = KIND_OVERFLOW;
			end
		end
		if (do_flush) begin
			pcount_d = '0;
		end
	end

	assign line_sw = (line_inc && line_q != LINE_SAT) ? 16'(line_q + 16'd1) : line_q;

	assign value_mode = (mode_sw == M_PRE_VALUE) || (mode_sw == M_VALUE) ||
	                    (mode_sw == M_VALUE_ESC) || (mode_sw == M_SQ) ||
	                    (mode_sw == M_SQ_ESC) || (mode_sw == M_DQ) ||
	                    (mode_sw == M_DQ_ESC);

	always_comb begin
		tail_v    = 1'b0;
		tail_kind = KIND_PAIR_END;
		mode_d    = mode_sw;
		line_d    = line_sw;
		if (end_of_text) begin
			tail_v    = value_mode || (mode_sw == M_KEY);
			tail_kind = value_mode ? KIND_PAIR_END : KIND_DISCARD;
			mode_d    = M_PRE_KEY;
			line_d    = LINE_FIRST;
		end
	end

	always_comb begin
		plan.flush_kind = flush_kind;
		plan.main_v     = main_v;
		plan.main_kind  = main_kind;
		plan.main_byte  = (main_kind == KIND_KEY || main_kind == KIND_VALUE) ? text_byte : 8'd0;
		plan.tail_v     = tail_v;
		plan.tail_kind  = tail_kind;
		plan.line       = line_sw;
		flush_n         = do_flush ? pcount_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_PRE_KEY;
			line_q   <= LINE_FIRST;
			pcount_q <= '0;
			nl_a_q   <= NL_A_RESET;
			nl_b_q   <= NL_B_RESET;
		end else begin
			if (in_accept) begin
				mode_q   <= mode_d;
				line_q   <= line_d;
				pcount_q <= end_of_text ? '0 : pcount_d;
			end
			if (wr_en) begin
				case (wr_index)
					REG_NL_A: nl_a_q <= wr_data;
					REG_NL_B: nl_b_q <= wr_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && hold_wr) begin
			space_mem[pcount_q[IdxW-1:0]] <= text_byte;
		end
		if (rd_en) begin
			rd_data_q <= space_mem[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

	a_pcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcount_q <= CntW'(SPACE_DEPTH))
		else $error("whitespace count beyond buffer depth");

	a_eot_reset: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && end_of_text |=> mode_q == M_PRE_KEY && line_q == LINE_FIRST &&
		pcount_q == '0)
		else $error("state not restored after final byte");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != 16'd0)
		else $error("line counter wrapped to zero");

endmodule

// ===== sv/envkv_emit.sv =====
// ----------------------------------------------------------------------------
// envkv_emit
// Holds one item's result plan and, while the output register is free, issues
// one result per cycle into it: held whitespace, main, end-of-text result.
// ----------------------------------------------------------------------------
module envkv_emit import envkv_pkg::*; #(
	parameter int SPACE_DEPTH = SPACE_DEPTH_DEF,
	parameter int CntW = $clog2(SPACE_DEPTH + 1),
	parameter int IdxW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            plan_load,
	input  plan_t           plan,
	input  logic [CntW-1:0] flush_n,
	output logic            load_ok,
	output logic            rd_en,
	output logic [IdxW-1:0] rd_idx,
	input  logic [7:0]      rd_data,
	envkv_out_if.source     tok
);

	plan_t           plan_q;
	logic [CntW-1:0] flush_n_q, idx_q, fl_left;
	logic            main_v_q, tail_v_q;
	logic            fl_more, rem_zero, rem_one, out_free, emit;

	logic            out_valid_q, out_mem_q, out_last_q;
	kind_t           out_kind_q;
	logic [7:0]      out_byte_q;
	logic [15:0]     out_line_q;

	assign fl_more  = idx_q != flush_n_q;
	assign fl_left  = flush_n_q - idx_q;
	assign rem_zero = !fl_more && !main_v_q && !tail_v_q;
	assign rem_one  = (fl_left == CntW'(1) && !main_v_q && !tail_v_q) ||
	                  (!fl_more && (main_v_q ^ tail_v_q));
	assign out_free = !out_valid_q || tok.ready;
	assign emit     = !rem_zero && out_free;
	assign load_ok  = rem_zero || (rem_one && out_free);
	assign rd_en    = emit && fl_more;
	assign rd_idx   = idx_q[IdxW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_n_q   <= '0;
			idx_q       <= '0;
			main_v_q    <= 1'b0;
			tail_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_mem_q   <= 1'b0;
		end else begin
			if (plan_load) begin
				flush_n_q <= flush_n;
				idx_q     <= '0;
				main_v_q  <= plan.main_v;
				tail_v_q  <= plan.tail_v;
			end else if (emit) begin
				if (fl_more) begin
					idx_q <= idx_q + CntW'(1);
				end else if (main_v_q) begin
					main_v_q <= 1'b0;
				end else begin
					tail_v_q <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_mem_q   <= fl_more;
			end else if (tok.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (plan_load) begin
			plan_q <= plan;
		end
		if (emit) begin
			out_kind_q <= fl_more ? plan_q.flush_kind :
			              main_v_q ? plan_q.main_kind : plan_q.tail_kind;
			out_byte_q <= (!fl_more && main_v_q) ? plan_q.main_byte : 8'd0;
			out_line_q <= plan_q.line;
			out_last_q <= rem_one;
		end
	end

	assign tok.valid       = out_valid_q;
	assign tok.token_kind  = out_kind_q;
	assign tok.token_byte  = out_mem_q ? rd_data : out_byte_q;
	assign tok.line_number = out_line_q;
	assign tok.run_last    = out_last_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= flush_n_q && flush_n_q <= CntW'(SPACE_DEPTH))
		else $error("flush pointer beyond plan");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		emit && rem_one && !plan_load |=> rem_zero)
		else $error("plan not empty after its last result");

	a_load_safe: assert property (@(posedge clk) disable iff (!arst_n)
		plan_load |-> rem_zero || (rem_one && emit))
		else $error("plan overwritten with results pending");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		emit && rem_one |=> out_valid_q && out_last_q)
		else $error("final result of an item not marked");

endmodule

// ===== sv/env_file_key_value_parser.sv =====
// ----------------------------------------------------------------------------
// env_file_key_value_parser
// Environment-file tokenizer: splits text bytes into key and value bytes,
// pair-end, discarded-key and whitespace-overflow tokens.
// ----------------------------------------------------------------------------
// Usage:
//   text_ch carries one file byte per transaction with end_of_text on the
//   final byte. token_ch carries tokens; run_last marks the last token caused
//   by one byte. wr_en/wr_index/wr_data set the two line-end bytes; write them
//   only while no byte is in flight.
//   Each byte's result plan is registered, then its tokens pass through the
//   single output register. Bytes that cause one token or none stream at one
//   per cycle while tokens are taken. A byte with more tokens holds text_ch
//   until its last token issues; they leave one per cycle while the output
//   register is free, the held whitespace read one entry a cycle from the
//   SPACE_DEPTH-entry buffer. At most SPACE_DEPTH + 2 tokens come from a byte.
//   Reset clears the parse state to before-key, the line count to one, the
//   held whitespace and both channels; the line-end bytes return to LF and CR.
//   When the token receiver stalls, the output register holds its token;
//   bytes that cause no token still pass, and at most one byte that causes
//   tokens is taken before text_ch deasserts ready.
// ----------------------------------------------------------------------------
module env_file_key_value_parser import envkv_pkg::*; #(
	parameter int SPACE_DEPTH = SPACE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [7:0]           wr_data,
	envkv_in_if.sink             text_ch,
	envkv_out_if.source          token_ch
);

	localparam int CntW = $clog2(SPACE_DEPTH + 1);
	localparam int IdxW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;

	plan_t           plan;
	logic [CntW-1:0] flush_n;
	logic            load_ok, in_accept;
	logic            rd_en;
	logic [IdxW-1:0] rd_idx;
	logic [7:0]      rd_data;

	assign text_ch.ready = load_ok;
	assign in_accept     = text_ch.valid && load_ok;

	envkv_parse #(
		.SPACE_DEPTH (SPACE_DEPTH),
		.CntW        (CntW),
		.IdxW        (IdxW)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.in_accept   (in_accept),
		.text_byte   (text_ch.text_byte),
		.end_of_text (text_ch.end_of_text),
		.plan        (plan),
		.flush_n     (flush_n),
		.rd_en       (rd_en),
		.rd_idx      (rd_idx),
		.rd_data     (rd_data)
	);

	envkv_emit #(
		.SPACE_DEPTH (SPACE_DEPTH),
		.CntW        (CntW),
		.IdxW        (IdxW)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.plan_load (in_accept),
		.plan      (plan),
		.flush_n   (flush_n),
		.load_ok   (load_ok),
		.rd_en     (rd_en),
		.rd_idx    (rd_idx),
		.rd_data   (rd_data),
		.tok       (token_ch)
	);

endmodule

// ===== tb/sv/env_file_key_value_parser_tb.sv =====
// ----------------------------------------------------------------------------
// env_file_key_value_parser_tb
// Self-checking bench for the environment-file tokenizer. A directed table
// walks every parse mode but the unquoted-value escape, escaped line ends,
// blank overflow and the largest token burst. Random lines follow: mostly
// well-formed key=value pairs, with some comments, bare keys, noise and broken
// quoting, under several line-end settings. A built-in tokenizer predicts
// every token not given by a typed row, and each token is compared in order.
// ----------------------------------------------------------------------------
module env_file_key_value_parser_tb;
	import envkv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT     = 2000000;
	localparam int PHASE_ITEMS     = 40;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int SETTLE_CYCLES   = 8;
	localparam int MAX_REPORTS     = 10;

	typedef enum logic [3:0] {
		PM_PRE_KEY, PM_KEY, PM_PRE_VALUE, PM_VALUE, PM_VALUE_ESC, PM_SQ, PM_SQ_ESC,
		PM_DQ, PM_DQ_ESC, PM_COMMENT, PM_COMMENT_ESC
	} parse_mode_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] line;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [7:0] c;
		logic       eot;
		logic [4:0] reps;
		logic       typed;
		token_t     tok;
	} stim_row_t;

	localparam token_t NO_TOKEN = '{KIND_KEY, 8'h00, 16'h0000, 1'b0};

	// Typed rows carry the single token they must produce.
	localparam stim_row_t DIRECTED_ROWS [0:32] = '{
		'{8'h41,     1'b0, 5'd1,  1'b1, '{KIND_KEY, 8'h41, 16'd1, 1'b1}},
		'{CH_SPACE,  1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_TAB,    1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{8'h42,     1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_EQUAL,  1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_SPACE,  1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_SQUOTE, 1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{8'h78,     1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_BSLASH, 1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_LF,     1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_SQUOTE, 1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_LF,     1'b0, 5'd1,  1'b1, '{KIND_PAIR_END, 8'h00, 16'd2, 1'b1}},
		'{CH_HASH,   1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_BSLASH, 1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_LF,     1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_CR,     1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{8'h4B,     1'b0, 5'd1,  1'b1, '{KIND_KEY, 8'h4B, 16'd3, 1'b1}},
		'{CH_CR,     1'b0, 5'd1,  1'b1, '{KIND_DISCARD, 8'h00, 16'd4, 1'b1}},
		'{8'h76,     1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_EQUAL,  1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_DQUOTE, 1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_BSLASH, 1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_DQUOTE, 1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{8'hFF,     1'b0, 5'd1,  1'b1, '{KIND_VALUE, 8'hFF, 16'd4, 1'b1}},
		'{CH_DQUOTE, 1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{8'h7A,     1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{CH_SPACE,  1'b0, 5'd16, 1'b0, NO_TOKEN},
		'{CH_SPACE,  1'b0, 5'd1,  1'b1, '{KIND_OVERFLOW, 8'h00, 16'd4, 1'b1}},
		'{8'h7A,     1'b0, 5'd1,  1'b0, NO_TOKEN},
		'{8'h00,     1'b1, 5'd1,  1'b0, NO_TOKEN},
		'{8'h6B,     1'b0, 5'd1,  1'b1, '{KIND_KEY, 8'h6B, 16'd1, 1'b1}},
		'{CH_SPACE,  1'b0, 5'd16, 1'b0, NO_TOKEN},
		'{8'h63,     1'b1, 5'd1,  1'b0, NO_TOKEN}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index = REG_NL_A;
	logic [7:0]           wr_data = 8'h00;

	envkv_in_if  text_ch ();
	envkv_out_if token_ch ();

	env_file_key_value_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.text_ch  (text_ch),
		.token_ch (token_ch)
	);

	always #2 clk = ~clk;

	// Tokenizer state as the bench sees it
	logic [7:0]  nl_a, nl_b;
	parse_mode_t mode_now;
	logic [15:0] line_now;
	logic [7:0]  held_ws [SPACE_DEPTH_DEF];
	int          held_count;
	token_t      token_forecast [$];

	bit tx_idle_on, rx_idle_on, hold_off_req;
	int items_sent, mismatch_count, cycle_count;

	function automatic int pick_gap(input bit on);
		int r;
		r = $urandom_range(0, 99);
		if (!on || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic bit is_line_end(input logic [7:0] c);
		return c == nl_a || c == nl_b;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	task automatic push_token(input kind_t k, input logic [7:0] b);
		token_t t;
		t.kind = k;
		t.data = (k == KIND_KEY || k == KIND_VALUE) ? b : 8'h00;
		t.line = line_now;
		t.last = 1'b0;
		token_forecast.push_back(t);
	endtask

	task automatic bump_line();
		if (line_now != LINE_SAT)
			line_now++;
	endtask

	task automatic flush_held(input kind_t k);
		for (int i = 0; i < held_count; i++)
			push_token(k, held_ws[i]);
		held_count = 0;
	endtask

	task automatic hold_blank(input logic [7:0] c);
		if (held_count < SPACE_DEPTH_DEF) begin
			held_ws[held_count] = c;
			held_count++;
		end else begin
			push_token(KIND_OVERFLOW, 8'h00);
		end
	endtask

	task automatic tokenize_byte(input logic [7:0] c, input logic eot);
		int first;
		first = token_forecast.size();
		case (mode_now)
			PM_KEY: begin
				if (is_line_end(c)) begin
					mode_now = PM_PRE_KEY;
					held_count = 0;
					bump_line();
					push_token(KIND_DISCARD, 8'h00);
				end else if (c == CH_EQUAL) begin
					mode_now = PM_PRE_VALUE;
					held_count = 0;
				end else if (is_blank(c)) begin
					hold_blank(c);
				end else begin
					flush_held(KIND_KEY);
					push_token(KIND_KEY, c);
				end
			end
			PM_PRE_VALUE: begin
				if (is_line_end(c)) begin
					mode_now = PM_PRE_KEY;
					bump_line();
					push_token(KIND_PAIR_END, 8'h00);
				end else if (c == CH_SQUOTE) begin
					mode_now = PM_SQ;
				end else if (c == CH_DQUOTE) begin
					mode_now = PM_DQ;
				end else if (c == CH_BSLASH) begin
					mode_now = PM_VALUE_ESC;
				end else if (!is_blank(c)) begin
					mode_now = PM_VALUE;
					push_token(KIND_VALUE, c);
				end
			end
			PM_VALUE: begin
				if (is_line_end(c)) begin
					mode_now = PM_PRE_KEY;
					held_count = 0;
					bump_line();
					push_token(KIND_PAIR_END, 8'h00);
				end else if (c == CH_BSLASH) begin
					flush_held(KIND_VALUE);
					mode_now = PM_VALUE_ESC;
				end else if (is_blank(c)) begin
					hold_blank(c);
				end else begin
					flush_held(KIND_VALUE);
					push_token(KIND_VALUE, c);
				end
			end
			PM_VALUE_ESC, PM_SQ_ESC, PM_DQ_ESC: begin
				if (mode_now == PM_VALUE_ESC)
					mode_now = PM_VALUE;
				else if (mode_now == PM_SQ_ESC)
					mode_now = PM_SQ;
				else
					mode_now = PM_DQ;
				// drop an escaped line end
				if (!is_line_end(c))
					push_token(KIND_VALUE, c);
			end
			PM_SQ: begin
				if (c == CH_SQUOTE)
					mode_now = PM_PRE_VALUE;
				else if (c == CH_BSLASH)
					mode_now = PM_SQ_ESC;
				else
					push_token(KIND_VALUE, c);
			end
			PM_DQ: begin
				if (c == CH_DQUOTE)
					mode_now = PM_PRE_VALUE;
				else if (c == CH_BSLASH)
					mode_now = PM_DQ_ESC;
				else
					push_token(KIND_VALUE, c);
			end
			PM_COMMENT: begin
				if (c == CH_BSLASH) begin
					mode_now = PM_COMMENT_ESC;
				end else if (is_line_end(c)) begin
					mode_now = PM_PRE_KEY;
					bump_line();
				end
			end
			PM_COMMENT_ESC: mode_now = PM_COMMENT;
			default: begin
				if (c == CH_HASH || c == CH_SEMI) begin
					mode_now = PM_COMMENT;
				end else if (!is_blank(c)) begin
					mode_now = PM_KEY;
					held_count = 0;
					push_token(KIND_KEY, c);
				end else begin
					mode_now = PM_PRE_KEY;
				end
			end
		endcase
		if (eot) begin
			if (mode_now >= PM_PRE_VALUE && mode_now <= PM_DQ_ESC)
				push_token(KIND_PAIR_END, 8'h00);
			else if (mode_now == PM_KEY)
				push_token(KIND_DISCARD, 8'h00);
			mode_now = PM_PRE_KEY;
			line_now = LINE_FIRST;
			held_count = 0;
		end
		if (token_forecast.size() > first)
			token_forecast[$].last = 1'b1;
	endtask

	task automatic send_text(input logic [7:0] c, input logic eot, input bit typed,
			input token_t typed_tok);
		int gap, first;
		gap = pick_gap(tx_idle_on);
		@(negedge clk);
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= c;
		text_ch.end_of_text <= eot;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		first = token_forecast.size();
		tokenize_byte(c, eot);
		if (typed) begin
			while (token_forecast.size() > first)
				void'(token_forecast.pop_back());
			token_forecast.push_back(typed_tok);
		end
	endtask

	task automatic put(input logic [7:0] c);
		send_text(c, $urandom_range(0, 299) == 0, 1'b0, NO_TOKEN);
		items_sent++;
	endtask

	task automatic end_line();
		send_text($urandom_range(0, 1) ? nl_a : nl_b, $urandom_range(0, 99) < 8,
			1'b0, NO_TOKEN);
		items_sent++;
	endtask

	function automatic logic [7:0] name_char();
		int r;
		r = $urandom_range(0, 63);
		if (r < 26)
			return 8'h61 + 8'(r);
		if (r < 52)
			return 8'h41 + 8'(r - 26);
		if (r < 62)
			return 8'h30 + 8'(r - 52);
		return 8'h5F;
	endfunction

	function automatic logic [7:0] blank_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return CH_SPACE;
		if (r < 9)
			return CH_TAB;
		return $urandom_range(0, 1) ? CH_LF : CH_CR;
	endfunction

	function automatic logic [7:0] esc_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return $urandom_range(0, 1) ? nl_a : nl_b;
		if (r < 5)
			return $urandom_range(0, 1) ? CH_BSLASH : CH_DQUOTE;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic put_blanks();
		int r, n;
		r = $urandom_range(0, 99);
		n = r < 55 ? 0 : r < 85 ? $urandom_range(1, 3) : r < 95 ? $urandom_range(4, 12) :
			$urandom_range(14, 20);
		repeat (n) put(blank_char());
	endtask

	task automatic put_name();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) put(name_char());
	endtask

	task automatic put_value();
		int segs, n;
		logic [7:0] q;
		segs = $urandom_range(1, 3);
		repeat (segs) begin
			if ($urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 5);
				repeat (n) put(name_char());
				if ($urandom_range(0, 3) == 0) begin
					put(CH_BSLASH);
					put(esc_byte());
				end
				put_blanks();
			end else begin
				q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
				put(q);
				n = $urandom_range(0, 6);
				repeat (n) begin
					if ($urandom_range(0, 4) == 0) begin
						put(CH_BSLASH);
						put(esc_byte());
					end else begin
						put($urandom_range(0, 5) == 0 ? CH_SPACE : name_char());
					end
				end
				// leave the quote open now and then
				if ($urandom_range(0, 19) != 0)
					put(q);
			end
		end
	endtask

	task automatic send_line();
		int shape, n;
		tx_idle_on = $urandom_range(0, 3) != 0;
		rx_idle_on = $urandom_range(0, 3) != 0;
		shape = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0)
			put_blanks();
		if (shape < 10) begin
			put($urandom_range(0, 1) ? CH_HASH : CH_SEMI);
			n = $urandom_range(0, 8);
			repeat (n) put($urandom_range(0, 5) == 0 ? CH_BSLASH : name_char());
		end else if (shape < 17) begin
			put_name();
			put_blanks();
		end else if (shape < 22) begin
			put_blanks();
		end else if (shape < 27) begin
			n = $urandom_range(1, 10);
			repeat (n) put(8'($urandom_range(0, 255)));
		end else begin
			put_name();
			put_blanks();
			put(CH_EQUAL);
			put_blanks();
			put_value();
		end
		end_line();
	endtask

	task automatic settle();
		@(negedge clk);
		text_ch.valid <= 1'b0;
		while (token_forecast.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_line_ends(input logic [7:0] a, input logic [7:0] b);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= REG_NL_A;
		wr_data <= a;
		@(negedge clk);
		wr_index <= REG_NL_B;
		wr_data <= b;
		@(negedge clk);
		wr_en <= 1'b0;
		nl_a = a;
		nl_b = b;
	endtask

	initial begin : stimulus
		text_ch.valid = 1'b0;
		text_ch.text_byte = 8'h00;
		text_ch.end_of_text = 1'b0;
		nl_a = NL_A_RESET;
		nl_b = NL_B_RESET;
		mode_now = PM_PRE_KEY;
		line_now = LINE_FIRST;
		held_count = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_ROWS[i])
			repeat (DIRECTED_ROWS[i].reps)
				send_text(DIRECTED_ROWS[i].c, DIRECTED_ROWS[i].eot, DIRECTED_ROWS[i].typed,
					DIRECTED_ROWS[i].tok);

		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				settle();
				case (p)
					1: set_line_ends(8'h00, 8'hFF);
					2: set_line_ends(8'hFF, 8'h00);
					3: set_line_ends(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
					default: set_line_ends(NL_A_RESET, NL_B_RESET);
				endcase
			end
			if (p == 1)
				hold_off_req = 1'b1;
			items_sent = 0;
			while (items_sent < PHASE_ITEMS)
				send_line();
		end

		settle();
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : token_sink
		int stall_left;
		stall_left = 0;
		token_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
			end else if (stall_left == 0) begin
				stall_left = pick_gap(rx_idle_on);
			end
			if (stall_left > 0) begin
				token_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				token_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : token_check
		token_t want;
		if (arst_n && token_ch.valid && token_ch.ready) begin
			if (token_forecast.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("ERROR: unexpected token kind=%0d byte=%02h line=%0d last=%0b",
						token_ch.token_kind, token_ch.token_byte, token_ch.line_number,
						token_ch.run_last);
			end else begin
				want = token_forecast.pop_front();
				if (token_ch.token_kind !== want.kind || token_ch.token_byte !== want.data ||
						token_ch.line_number !== want.line || token_ch.run_last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"ERROR: token mismatch: expected kind=%0d byte=%02h line=%0d ",
							"last=%0b, got kind=%0d byte=%02h line=%0d last=%0b"},
							want.kind, want.data, want.line, want.last, token_ch.token_kind,
							token_ch.token_byte, token_ch.line_number, token_ch.run_last);
				end
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

endmodule
